// ----- hw/rtl/spsp_pkg.sv -----
package spsp_pkg;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] profile_idc;
    logic [7:0] constraint_flags;
    logic [7:0] level_idc;
    logic [1:0] chroma_fmt;
    logic [2:0] luma_depth_minus8;
    logic [2:0] chroma_depth_minus8;
    logic [1:0] status;
  } out_item_t;

  localparam int unsigned ACC_W = 17;

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;

  localparam logic [7:0] PROFILE_HIGH    = 8'd100;
  localparam logic [7:0] PROFILE_HIGH10  = 8'd110;
  localparam logic [7:0] PROFILE_HIGH422 = 8'd122;
  localparam logic [7:0] PROFILE_HIGH444 = 8'd144;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Byte position within the unit
  localparam logic [2:0] BC_HEADER  = 3'd0;
  localparam logic [2:0] BC_PROFILE = 3'd1;
  localparam logic [2:0] BC_COMPAT  = 3'd2;
  localparam logic [2:0] BC_LEVEL   = 3'd3;
  localparam logic [2:0] BC_PAYLOAD = 3'd4;

  // Field being decoded from the bit payload
  localparam logic [2:0] FS_SPS_ID  = 3'd0;
  localparam logic [2:0] FS_CHROMA  = 3'd1;
  localparam logic [2:0] FS_PLANE   = 3'd2;
  localparam logic [2:0] FS_LUMA    = 3'd3;
  localparam logic [2:0] FS_CDEPTH  = 3'd4;

  localparam logic [1:0] CHROMA_DEFAULT = 2'd1;
  localparam logic [1:0] CHROMA_MAX     = 2'd3;
  localparam logic [2:0] DEPTH_MAX      = 3'd6;

endpackage

// ----- hw/rtl/sps_header_field_parser.sv -----
// From input accept to out_valid a byte passes the input register, then the result register.
// Throughput: one byte per cycle unless out_ready low holds a pending result; the eight
// exp-Golomb bit steps per byte are combinational between input and parser state registers.
// Reset (rst_n low, synchronous): clears valids, the unit state and all decoded
// fields of the parser state (out_item is not reset); chroma format returns to 1.
module sps_header_field_parser #(
  parameter int unsigned MAX_LEADING_ZEROS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spsp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spsp_pkg::out_item_t  out_item
);

  localparam int unsigned ZW = $clog2(MAX_LEADING_ZEROS + 1);
  localparam int unsigned AW = spsp_pkg::ACC_W;

  typedef struct packed {
    logic          in_sps;
    logic          finished;
    logic [2:0]    byte_count;
    logic [2:0]    field_step;
    logic [ZW-1:0] zero_run;
    logic          in_suffix;
    logic [ZW-1:0] suffix_left;
    logic [AW-1:0] code_accum;
    logic [7:0]    profile;
    logic [7:0]    compat;
    logic [7:0]    level;
    logic [1:0]    chroma;
    logic [2:0]    luma_depth;
    logic [2:0]    chroma_depth;
    logic          range_error;
  } parse_st_t;

  typedef struct packed {
    parse_st_t  s;
    logic       fire;
    logic [1:0] stat;
  } parse_res_t;

  function automatic parse_res_t emit_res(parse_res_t r, logic [1:0] stat);
    parse_res_t o;
    o = r;
    o.fire       = 1'b1;
    o.stat       = stat;
    o.s.finished = 1'b1;
    return o;
  endfunction

  function automatic parse_res_t finish_code(parse_res_t r);
    parse_res_t    o;
    logic [AW-1:0] v;
    o = r;
    v = (o.s.code_accum != '0) ? o.s.code_accum - AW'(1) : '0;
    o.s.in_suffix   = 1'b0;
    o.s.zero_run    = '0;
    o.s.suffix_left = '0;
    o.s.code_accum  = '0;
    unique case (o.s.field_step)
      spsp_pkg::FS_SPS_ID: begin
        o.s.field_step = spsp_pkg::FS_CHROMA;
      end
      spsp_pkg::FS_CHROMA: begin
        if (v > AW'(spsp_pkg::CHROMA_MAX)) begin
          o.s.range_error = 1'b1;
          o.s.chroma      = spsp_pkg::CHROMA_MAX;
        end else begin
          o.s.chroma = v[1:0];
        end
        // Separate-plane flag follows only for 4:4:4
        o.s.field_step = (o.s.chroma == spsp_pkg::CHROMA_MAX) ? spsp_pkg::FS_PLANE
                                                              : spsp_pkg::FS_LUMA;
      end
      spsp_pkg::FS_LUMA: begin
        if (v > AW'(spsp_pkg::DEPTH_MAX)) begin
          o.s.range_error = 1'b1;
          o.s.luma_depth  = spsp_pkg::DEPTH_MAX;
        end else begin
          o.s.luma_depth = v[2:0];
        end
        o.s.field_step = spsp_pkg::FS_CDEPTH;
      end
      default: begin
        if (v > AW'(spsp_pkg::DEPTH_MAX)) begin
          o.s.range_error  = 1'b1;
          o.s.chroma_depth = spsp_pkg::DEPTH_MAX;
        end else begin
          o.s.chroma_depth = v[2:0];
        end
        o = emit_res(o, o.s.range_error ? spsp_pkg::STATUS_RANGE : spsp_pkg::STATUS_OK);
      end
    endcase
    return o;
  endfunction

  function automatic parse_res_t take_bit(parse_res_t r, logic b);
    parse_res_t o;
    o = r;
    if (!o.s.finished) begin
      if (o.s.field_step == spsp_pkg::FS_PLANE) begin
        o.s.field_step = spsp_pkg::FS_LUMA;
      end else if (!o.s.in_suffix) begin
        if (!b) begin
          if (o.s.zero_run >= ZW'(MAX_LEADING_ZEROS)) begin
            o.s.range_error = 1'b1;
            o = emit_res(o, spsp_pkg::STATUS_RANGE);
          end else begin
            o.s.zero_run = o.s.zero_run + ZW'(1);
          end
        end else begin
          o.s.code_accum = AW'(1);
          if (o.s.zero_run == '0) begin
            o = finish_code(o);
          end else begin
            o.s.in_suffix   = 1'b1;
            o.s.suffix_left = o.s.zero_run;
          end
        end
      end else begin
        // Saturate the accumulator at all ones
        o.s.code_accum  = o.s.code_accum[AW-1] ? '1 : {o.s.code_accum[AW-2:0], b};
        o.s.suffix_left = o.s.suffix_left - ZW'(1);
        if (o.s.suffix_left == '0) begin
          o = finish_code(o);
        end
      end
    end
    return o;
  endfunction

  function automatic parse_st_t cleared(logic in_sps);
    parse_st_t s;
    s = '0;
    s.in_sps = in_sps;
    s.chroma = spsp_pkg::CHROMA_DEFAULT;
    return s;
  endfunction

  logic                stg_vld_r;
  spsp_pkg::in_item_t  stg_r;
  parse_st_t           st_r;
  logic                out_vld_r;
  spsp_pkg::out_item_t out_r;

  logic       stg_adv;
  parse_res_t res;

  assign stg_adv   = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !stg_vld_r || stg_adv;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  always_comb begin
    res      = '0;
    res.s    = st_r;
    res.fire = 1'b0;
    res.stat = spsp_pkg::STATUS_OK;
    if (stg_r.first_byte) begin
      res.s            = cleared(stg_r.nal_byte[4:0] == spsp_pkg::NAL_TYPE_SPS);
      res.s.byte_count = spsp_pkg::BC_PROFILE;
    end else if (res.s.in_sps && !res.s.finished) begin
      unique case (res.s.byte_count)
        spsp_pkg::BC_PROFILE: begin
          res.s.profile    = stg_r.nal_byte;
          res.s.byte_count = spsp_pkg::BC_COMPAT;
        end
        spsp_pkg::BC_COMPAT: begin
          res.s.compat     = stg_r.nal_byte;
          res.s.byte_count = spsp_pkg::BC_LEVEL;
        end
        spsp_pkg::BC_LEVEL: begin
          res.s.level      = stg_r.nal_byte;
          res.s.byte_count = spsp_pkg::BC_PAYLOAD;
          if (!(res.s.profile == spsp_pkg::PROFILE_HIGH    ||
                res.s.profile == spsp_pkg::PROFILE_HIGH10  ||
                res.s.profile == spsp_pkg::PROFILE_HIGH422 ||
                res.s.profile == spsp_pkg::PROFILE_HIGH444)) begin
            res = emit_res(res, spsp_pkg::STATUS_OK);
          end
        end
        default: begin
          // Walk the byte MSB first
          for (int i = 7; i >= 0; i--) begin
            res = take_bit(res, stg_r.nal_byte[i]);
          end
        end
      endcase
    end
    if (stg_r.last_byte) begin
      if (res.s.in_sps && !res.s.finished) begin
        res = emit_res(res, res.s.range_error ? spsp_pkg::STATUS_RANGE
                                              : spsp_pkg::STATUS_SHORT);
      end
      res.s.in_sps = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      st_r      <= cleared(1'b0);
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_vld_r <= in_valid;
      end
      if (stg_adv) begin
        st_r <= res.s;
      end
      if (stg_adv && res.fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_r <= in_item;
    end
    if (stg_adv && res.fire) begin
      out_r.profile_idc         <= res.s.profile;
      out_r.constraint_flags    <= res.s.compat;
      out_r.level_idc           <= res.s.level;
      out_r.chroma_fmt          <= res.s.chroma;
      out_r.luma_depth_minus8   <= res.s.luma_depth;
      out_r.chroma_depth_minus8 <= res.s.chroma_depth;
      out_r.status              <= res.stat;
    end
  end

endmodule
